### rtl/core/ppsc_pkg.sv
`timescale 1ns / 1ps

package ppsc_pkg;

  // Register indexes of the configuration port
  localparam logic [2:0] CFG_MODE     = 3'd0;
  localparam logic [2:0] CFG_CENTER_X = 3'd1;
  localparam logic [2:0] CFG_CENTER_Y = 3'd2;
  localparam logic [2:0] CFG_CENTER_Z = 3'd3;
  localparam logic [2:0] CFG_RADIUS   = 3'd4;

  localparam logic       MODE_SPHERE   = 1'b0;
  localparam logic       MODE_CYLINDER = 1'b1;

  localparam logic [30:0] RADIUS_RESET = 31'd65536;

  // The largest normalized magnitude sits in [2^23, 2^24)
  localparam int NORM_MSB = 23;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } point_t;

  typedef struct packed {
    logic signed [31:0] mapped_x;
    logic signed [31:0] mapped_y;
    logic signed [31:0] mapped_z;
  } mapped_t;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [30:0]        radius;
  } cfg_t;

  // Per-item flags that ride along the chains
  typedef struct packed {
    logic [2:0]         neg;
    logic               zero;
    logic signed [31:0] pz;
  } side_t;

  // One beat of the square-root chain
  typedef struct packed {
    logic              valid;
    logic [33:0]       rem;
    logic [31:0]       root;
    logic [63:0]       rad;
    logic [2:0][54:0]  prod;
    side_t             side;
  } sq_beat_t;

  // One beat of the divider chain, three lanes sharing one divisor
  typedef struct packed {
    logic             valid;
    logic [31:0]      dvs;
    logic [2:0][31:0] rem;
    logic [2:0][30:0] low;
    logic [2:0][30:0] quo;
    side_t            side;
  } dv_beat_t;

endpackage

### rtl/core/ppsc_front.sv
`timescale 1ns / 1ps

module ppsc_front import ppsc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  logic     point_valid,
  input  point_t   point,
  input  cfg_t     cfg,
  output sq_beat_t beat
);

  // stage 1: offsets from the center
  logic                    v1;
  logic signed [2:0][32:0] d1;
  logic signed [31:0]      pz1;
  // stage 2: magnitudes and their maximum
  logic                    v2;
  logic [2:0][31:0]        mag2;
  logic [31:0]             max2;
  side_t                   side2;
  // stage 3: leading one position
  logic                    v3;
  logic [2:0][31:0]        mag3;
  logic [4:0]              msb3;
  side_t                   side3;
  // stage 4: normalized magnitudes
  logic                    v4;
  logic [2:0][23:0]        a4;
  side_t                   side4;
  // stage 5: squares and radius products
  logic                    v5;
  logic [2:0][47:0]        sq5;
  logic [2:0][54:0]        prod5;
  side_t                   side5;

  logic signed [2:0][32:0] d_next;
  logic [2:0][31:0]        mag_next;
  logic [2:0]              neg_next;
  logic [31:0]             max_next;
  logic [4:0]              msb_next;
  logic [2:0][23:0]        a_next;
  logic [49:0]             sum_next;

  // Offsets, exact in 33 bits
  always_comb begin
    d_next[0] = {point.point_x[31], point.point_x} - {cfg.center_x[31], cfg.center_x};
    d_next[1] = {point.point_y[31], point.point_y} - {cfg.center_y[31], cfg.center_y};
    d_next[2] = {point.point_z[31], point.point_z} - {cfg.center_z[31], cfg.center_z};
  end

  // Magnitudes fit 32 bits; drop z for the cylinder
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_next[i] = d1[i][32];
      mag_next[i] = d1[i][32] ? 32'(-d1[i]) : d1[i][31:0];
    end
    if (cfg.mode == MODE_CYLINDER) begin
      mag_next[2] = '0;
    end
    max_next = mag_next[0];
    if (mag_next[1] > max_next) max_next = mag_next[1];
    if (mag_next[2] > max_next) max_next = mag_next[2];
  end

  // Find the leading one
  always_comb begin
    msb_next = '0;
    for (int b = 0; b < 32; b++) begin
      if (max2[b]) msb_next = 5'(b);
    end
  end

  // Shift so the largest lands in [2^23, 2^24)
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (msb3 >= 5'(NORM_MSB)) begin
        a_next[i] = 24'(mag3[i] >> (msb3 - 5'(NORM_MSB)));
      end else begin
        a_next[i] = 24'(mag3[i] << (5'(NORM_MSB) - msb3));
      end
    end
  end

  assign sum_next = 50'(sq5[0]) + 50'(sq5[1]) + 50'(sq5[2]);

  // Advance valids and payload
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      beat.valid <= 1'b0;
    end else if (en) begin
      v1 <= point_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      beat.valid <= v5;
      d1         <= d_next;
      pz1        <= point.point_z;
      mag2       <= mag_next;
      max2       <= max_next;
      side2.neg  <= neg_next;
      side2.zero <= (max_next == '0);
      side2.pz   <= pz1;
      mag3       <= mag2;
      msb3       <= msb_next;
      side3      <= side2;
      a4         <= a_next;
      side4      <= side3;
      for (int i = 0; i < 3; i++) begin
        sq5[i]   <= a4[i] * a4[i];
        prod5[i] <= a4[i] * cfg.radius;
      end
      side5      <= side4;
      beat.rem   <= '0;
      beat.root  <= '0;
      beat.rad   <= {sum_next, 14'd0};
      beat.prod  <= prod5;
      beat.side  <= side5;
    end
  end

endmodule

### rtl/core/ppsc_sqrt_cell.sv
`timescale 1ns / 1ps

module ppsc_sqrt_cell import ppsc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  sq_beat_t prev,
  output sq_beat_t beat
);

  logic [35:0] cur;
  logic [35:0] trial;
  logic        ge;
  sq_beat_t    beat_next;

  // Bring down two radicand bits, try the next root bit
  always_comb begin
    cur       = {prev.rem, prev.rad[63:62]};
    trial     = {2'b00, prev.root, 2'b01};
    ge        = (cur >= trial);
    beat_next = prev;
    beat_next.rem  = ge ? 34'(cur - trial) : cur[33:0];
    beat_next.root = {prev.root[30:0], ge};
    beat_next.rad  = {prev.rad[61:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat.valid <= 1'b0;
    end else if (en) begin
      beat <= beat_next;
    end
  end

endmodule

### rtl/core/ppsc_div_cell.sv
`timescale 1ns / 1ps

module ppsc_div_cell import ppsc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  dv_beat_t prev,
  output dv_beat_t beat
);

  logic [2:0][32:0] cur;
  logic [2:0]       ge;
  dv_beat_t         beat_next;

  // One restoring step per lane
  always_comb begin
    beat_next = prev;
    for (int i = 0; i < 3; i++) begin
      cur[i] = {prev.rem[i], prev.low[i][30]};
      ge[i]  = (cur[i] >= {1'b0, prev.dvs});
      beat_next.rem[i] = ge[i] ? 32'(cur[i] - {1'b0, prev.dvs}) : cur[i][31:0];
      beat_next.low[i] = {prev.low[i][29:0], 1'b0};
      beat_next.quo[i] = {prev.quo[i][29:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat.valid <= 1'b0;
    end else if (en) begin
      beat <= beat_next;
    end
  end

endmodule

### rtl/core/ppsc_back.sv
`timescale 1ns / 1ps

module ppsc_back import ppsc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  dv_beat_t prev,
  input  cfg_t     cfg,
  output logic     mapped_valid,
  output mapped_t  mapped
);

  logic signed [33:0] sum_x;
  logic signed [33:0] sum_y;
  logic signed [33:0] sum_z;
  logic signed [2:0][33:0] off;
  mapped_t            mapped_next;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -34'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Signed scaled offsets, then add back the center; a zero offset maps to the center plus the radius on x
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      off[i] = prev.side.neg[i] ? -$signed({3'b000, prev.quo[i]})
                                :  $signed({3'b000, prev.quo[i]});
    end
    if (prev.side.zero) begin
      sum_x = {{2{cfg.center_x[31]}}, cfg.center_x} + $signed({3'b000, cfg.radius});
      sum_y = {{2{cfg.center_y[31]}}, cfg.center_y};
      sum_z = {{2{cfg.center_z[31]}}, cfg.center_z};
    end else begin
      sum_x = {{2{cfg.center_x[31]}}, cfg.center_x} + off[0];
      sum_y = {{2{cfg.center_y[31]}}, cfg.center_y} + off[1];
      sum_z = {{2{cfg.center_z[31]}}, cfg.center_z} + off[2];
    end
    mapped_next.mapped_x = sat32(sum_x);
    mapped_next.mapped_y = sat32(sum_y);
    mapped_next.mapped_z = (cfg.mode == MODE_CYLINDER) ? prev.side.pz : sat32(sum_z);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      mapped_valid <= 1'b0;
    end else if (en) begin
      mapped_valid <= prev.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mapped <= mapped_next;
    end
  end

endmodule

### rtl/core/project_point_to_sphere_or_cylinder_top.sv
`timescale 1ns / 1ps
// channel   signals                                   dir   beat
// point     point_valid, point_ready, point           in    one point_t
// mapped    mapped_valid, mapped_ready, mapped        out   one mapped_t
// cfg       cfg_valid, cfg_ready, cfg_index, cfg_data in    one register write
//
// One point enters per cycle while the chain is not held; each passes 6 front stages, a chain of
// 32 square-root cells (one root bit each), a numerator stage, a chain of 31
// divider cells (one quotient bit each) and the output register.
// rst is synchronous and clears all valids and the configuration registers.
// The whole chain holds while the output register keeps a beat not taken;
// cfg_ready is always high.

module project_point_to_sphere_or_cylinder_top import ppsc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        point_valid,
  output logic        point_ready,
  input  point_t      point,
  output logic        mapped_valid,
  input  logic        mapped_ready,
  output mapped_t     mapped,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int SQ_CELLS = 32;
  localparam int DV_CELLS = 31;

  cfg_t     cfg;
  logic     en;
  sq_beat_t sq [SQ_CELLS+1];
  dv_beat_t dv [DV_CELLS+1];
  logic [61:0] num_next [3];

  assign en          = !mapped_valid || mapped_ready;
  assign point_ready = en;
  assign cfg_ready   = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode     <= MODE_SPHERE;
      cfg.center_x <= '0;
      cfg.center_y <= '0;
      cfg.center_z <= '0;
      cfg.radius   <= RADIUS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MODE:     cfg.mode     <= cfg_data[0];
        CFG_CENTER_X: cfg.center_x <= cfg_data;
        CFG_CENTER_Y: cfg.center_y <= cfg_data;
        CFG_CENTER_Z: cfg.center_z <= cfg_data;
        CFG_RADIUS:   cfg.radius   <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  ppsc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .point_valid (point_valid),
    .point       (point),
    .cfg         (cfg),
    .beat        (sq[0])
  );

  for (genvar k = 0; k < SQ_CELLS; k++) begin : g_sqrt
    ppsc_sqrt_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .prev (sq[k]),
      .beat (sq[k+1])
    );
  end

  // Numerator: product times 128 plus half the length
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num_next[i] = {sq[SQ_CELLS].prod[i], 7'd0} + 62'(sq[SQ_CELLS].root >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0].valid <= 1'b0;
    end else if (en) begin
      dv[0].valid <= sq[SQ_CELLS].valid;
      dv[0].dvs   <= sq[SQ_CELLS].root;
      dv[0].side  <= sq[SQ_CELLS].side;
      for (int i = 0; i < 3; i++) begin
        dv[0].rem[i] <= {1'b0, num_next[i][61:31]};
        dv[0].low[i] <= num_next[i][30:0];
        dv[0].quo[i] <= '0;
      end
    end
  end

  for (genvar k = 0; k < DV_CELLS; k++) begin : g_div
    ppsc_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .prev (dv[k]),
      .beat (dv[k+1])
    );
  end

  ppsc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .prev         (dv[DV_CELLS]),
    .cfg          (cfg),
    .mapped_valid (mapped_valid),
    .mapped       (mapped)
  );

`ifndef SYNTHESIS
  // Input stalls only behind a held output beat
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !point_ready |-> (mapped_valid && !mapped_ready))
    else $error("input stalled without a held output beat");

  // A new output beat appears only after the chain advanced
  a_out_advance: assert property (@(posedge clk) disable iff (rst)
    $rose(mapped_valid) |-> $past(en))
    else $error("output beat appeared while the chain was held");

  // Held chain keeps the valid of the last divider cell
  a_hold_last: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(dv[DV_CELLS].valid))
    else $error("last divider cell moved during a hold");
`endif

endmodule

### bench/project_point_to_sphere_or_cylinder_top_tb.sv
`timescale 1ns / 1ps

module project_point_to_sphere_or_cylinder_top_tb;
  import ppsc_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        point_valid = 1'b0;
  logic        point_ready;
  point_t      point = '0;
  logic        mapped_valid;
  logic        mapped_ready = 1'b0;
  mapped_t     mapped;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = CFG_MODE;
  logic [31:0] cfg_data = '0;

  // Shadow copy of the surface registers
  logic               sh_mode = MODE_SPHERE;
  logic signed [31:0] sh_cx = '0;
  logic signed [31:0] sh_cy = '0;
  logic signed [31:0] sh_cz = '0;
  logic [30:0]        sh_radius = RADIUS_RESET;

  point_t  pending_points[$];
  mapped_t expected_maps[$];
  int      gap_left = 0;
  int      stall_left = 0;
  bit      quiet = 1'b0;
  bit      long_hold_done = 1'b0;
  int      accepted = 0;
  int      checked = 0;
  int      errors = 0;
  int      n_sphere = 0;
  int      n_cylinder = 0;
  int      n_zero = 0;

  project_point_to_sphere_or_cylinder_top uut (
    .clk(clk), .rst(rst),
    .point_valid(point_valid), .point_ready(point_ready), .point(point),
    .mapped_valid(mapped_valid), .mapped_ready(mapped_ready), .mapped(mapped),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Projection of one point onto the configured surface
  function automatic mapped_t project_point(point_t p);
    longint      d[3];
    longint      q[3];
    logic [63:0] a[3];
    logic [63:0] m;
    logic [63:0] sum;
    logic [63:0] len;
    logic [63:0] v;
    int          n;
    int          sr;
    int          sl;
    mapped_t     r;
    d[0] = longint'(p.point_x) - longint'(sh_cx);
    d[1] = longint'(p.point_y) - longint'(sh_cy);
    d[2] = longint'(p.point_z) - longint'(sh_cz);
    n = (sh_mode == MODE_CYLINDER) ? 2 : 3;
    if (d[0] == 0 && d[1] == 0 && (n == 2 || d[2] == 0)) begin
      r.mapped_x = clamp32(longint'(sh_cx) + longint'(sh_radius));
      r.mapped_y = sh_cy;
      r.mapped_z = (n == 2) ? p.point_z : sh_cz;
      return r;
    end
    m = 0;
    sum = 0;
    sr = 0;
    sl = 0;
    for (int i = 0; i < n; i++) begin
      a[i] = d[i] < 0 ? -d[i] : d[i];
      if (a[i] > m) m = a[i];
    end
    while ((m >> sr) >= (64'd1 << 24)) sr++;
    while (((m >> sr) << sl) < (64'd1 << 23)) sl++;
    for (int i = 0; i < n; i++) begin
      a[i] = (a[i] >> sr) << sl;
      sum = sum + a[i] * a[i];
    end
    len = floor_sqrt(sum << 14);
    for (int i = 0; i < n; i++) begin
      v = (a[i] * {33'd0, sh_radius} * 128 + (len >> 1)) / len;
      q[i] = d[i] < 0 ? -longint'(v) : longint'(v);
    end
    r.mapped_x = clamp32(longint'(sh_cx) + q[0]);
    r.mapped_y = clamp32(longint'(sh_cy) + q[1]);
    r.mapped_z = (n == 2) ? p.point_z : clamp32(longint'(sh_cz) + q[2]);
    return r;
  endfunction

  function automatic int draw_wait();
    if (quiet) return 0;
    return $urandom_range(0, 10);
  endfunction

  // Offer points, record the projection of each accepted beat
  always @(posedge clk) begin
    if (rst) begin
      point_valid <= 1'b0;
    end else begin
      if (point_valid && point_ready) begin
        expected_maps.push_back(project_point(point));
        accepted++;
        if (sh_mode == MODE_CYLINDER) n_cylinder++;
        else n_sphere++;
        if (point.point_x == sh_cx && point.point_y == sh_cy &&
            (sh_mode == MODE_CYLINDER || point.point_z == sh_cz)) n_zero++;
      end
      if (!point_valid || point_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          point_valid <= 1'b0;
        end else if (pending_points.size() > 0) begin
          point <= pending_points.pop_front();
          point_valid <= 1'b1;
          gap_left <= draw_wait();
        end else begin
          point_valid <= 1'b0;
        end
      end
    end
  end

  // Take results, compare against the oldest projection
  always @(posedge clk) begin
    int s;
    mapped_t e;
    if (rst) begin
      mapped_ready <= 1'b0;
    end else begin
      s = stall_left;
      if (mapped_valid && mapped_ready) begin
        checked++;
        if (expected_maps.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat %h", $time, mapped);
        end else begin
          e = expected_maps.pop_front();
          if (e.mapped_x !== mapped.mapped_x)
            $display("%0t: mapped_x expected %h actual %h", $time, e.mapped_x, mapped.mapped_x);
          if (e.mapped_y !== mapped.mapped_y)
            $display("%0t: mapped_y expected %h actual %h", $time, e.mapped_y, mapped.mapped_y);
          if (e.mapped_z !== mapped.mapped_z)
            $display("%0t: mapped_z expected %h actual %h", $time, e.mapped_z, mapped.mapped_z);
          if (e !== mapped) errors++;
        end
        s = draw_wait();
      end
      // hold off once long enough to back up the whole chain
      if (!long_hold_done && accepted >= 300) begin
        long_hold_done <= 1'b1;
        s = 200;
      end
      if (s > 0) begin
        mapped_ready <= 1'b0;
        stall_left <= s - 1;
      end else begin
        mapped_ready <= 1'b1;
        stall_left <= 0;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MODE:     sh_mode = data[0];
      CFG_CENTER_X: sh_cx = data;
      CFG_CENTER_Y: sh_cy = data;
      CFG_CENTER_Z: sh_cz = data;
      CFG_RADIUS:   sh_radius = data[30:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic set_surface(logic md, logic [31:0] cx, logic [31:0] cy,
                             logic [31:0] cz, logic [31:0] rad);
    write_reg(CFG_MODE, {31'd0, md});
    write_reg(CFG_CENTER_X, cx);
    write_reg(CFG_CENTER_Y, cy);
    write_reg(CFG_CENTER_Z, cz);
    write_reg(CFG_RADIUS, rad);
  endtask

  // Wait until every offered point has come back, then let the chain settle
  task automatic drain();
    do @(posedge clk);
    while (pending_points.size() != 0 || point_valid || expected_maps.size() != 0);
    repeat (80) @(posedge clk);
  endtask

  function automatic point_t mk(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    point_t p;
    p.point_x = x;
    p.point_y = y;
    p.point_z = z;
    return p;
  endfunction

  function automatic logic [31:0] near(logic [31:0] c);
    logic [31:0] off;
    off = $urandom() >> $urandom_range(0, 31);
    return $urandom_range(0, 1) ? c + off : c - off;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      1: return $urandom() >> $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  function automatic point_t rand_point();
    case ($urandom_range(0, 5))
      0: return mk($urandom(), $urandom(), $urandom());
      1: return mk(rand_coord(), rand_coord(), rand_coord());
      2: return mk(sh_cx, sh_cy, $urandom_range(0, 1) ? sh_cz : near(sh_cz));
      3: return mk(near(sh_cx), sh_cy, sh_cz);
      default: return mk(near(sh_cx), near(sh_cy), near(sh_cz));
    endcase
  endfunction

  function automatic logic [31:0] rand_radius();
    case ($urandom_range(0, 4))
      0: return 32'd1;
      1: return 32'h7fffffff;
      2: return $urandom_range(1, 32'h7fffffff);
      default: return 1 + ($urandom() >> $urandom_range(1, 31));
    endcase
  endfunction

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Sphere at reset values: zero offset, extremes, tiny and huge offsets
    quiet = 1'b1;
    pending_points.push_back(mk(0, 0, 0));
    pending_points.push_back(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    pending_points.push_back(mk(32'h80000000, 32'h80000000, 32'h80000000));
    pending_points.push_back(mk(32'h7fffffff, 32'h80000000, 0));
    pending_points.push_back(mk(1, 0, 0));
    pending_points.push_back(mk(0, 32'hffffffff, 0));
    pending_points.push_back(mk(0, 0, 32'h00010000));
    pending_points.push_back(mk(3, 4, 32'hfffffff4));
    pending_points.push_back(mk(32'h01000000, 32'h00800000, 32'hff000000));
    drain();

    // Cylinder off the origin: z passes, zero XY offset
    set_surface(MODE_CYLINDER, 32'h00038000, 32'hfffe0000, 32'h12345678, 32'h00020000);
    quiet = 1'b0;
    pending_points.push_back(mk(32'h00038000, 32'hfffe0000, 32'h7fffffff));
    pending_points.push_back(mk(32'h00038000, 32'hfffe0000, 32'h80000000));
    pending_points.push_back(mk(32'h00038001, 32'hfffe0000, 0));
    pending_points.push_back(mk(32'h80000000, 32'h7fffffff, 32'h5a5a5a5a));
    pending_points.push_back(mk(0, 0, 32'ha5a5a5a5));
    pending_points.push_back(mk(32'h00038000, 32'h7fffffff, 1));
    drain();

    // Saturation at the top corner, then a zero radius
    set_surface(MODE_SPHERE, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    pending_points.push_back(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    pending_points.push_back(mk(32'h7ffffffe, 32'h7fffffff, 32'h7fffffff));
    pending_points.push_back(mk(32'h80000000, 32'h80000000, 32'h80000000));
    pending_points.push_back(mk(0, 32'h7fffffff, 32'h7fffffff));
    drain();
    set_surface(MODE_CYLINDER, 32'h80000000, 32'h80000000, 32'h80000000, 32'h0);
    pending_points.push_back(mk(32'h80000000, 32'h80000000, 32'h1));
    pending_points.push_back(mk(32'h7fffffff, 32'h00000000, 32'h2));
    drain();

    // Random surfaces, each phase drained before the next write
    for (int ph = 0; ph < 10; ph++) begin
      set_surface(1'($urandom_range(0, 1)), rand_coord(), rand_coord(), rand_coord(),
                  rand_radius());
      quiet = (ph % 3 == 1);
      for (int i = 0; i < 127; i++) pending_points.push_back(rand_point());
      drain();
    end

    if (mapped_valid) begin
      errors++;
      $display("%0t: stray beat after drain %h", $time, mapped);
    end
    $display("Checked %0d results: %0d sphere, %0d cylinder, %0d at zero offset.",
             checked, n_sphere, n_cylinder, n_zero);
    $display("Covered saturation, radius extremes and a long output stall.");
    if (errors == 0) begin
      $display("project_point_to_sphere_or_cylinder_top verification clean");
    end else begin
      $display("project_point_to_sphere_or_cylinder_top verification failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("project_point_to_sphere_or_cylinder_top verification failed");
    $finish;
  end

endmodule

### files.f
rtl/core/ppsc_pkg.sv
rtl/core/ppsc_front.sv
rtl/core/ppsc_sqrt_cell.sv
rtl/core/ppsc_div_cell.sv
rtl/core/ppsc_back.sv
rtl/core/project_point_to_sphere_or_cylinder_top.sv
bench/project_point_to_sphere_or_cylinder_top_tb.sv
